>>> rtl/tpe_pkg.sv
// ----------------------------------------------------------------------------
// tpe_pkg
// Types, constants and helpers shared by the triangle plane equation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tpe_pkg;

    // coordinate bits actually used, sign-extended from the top one
    localparam int COORD_WIDTH = 32;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;

    localparam logic [31:0] DEG_LIMIT_RESET = 32'd4295;

    // element 0 is x, 1 is y, 2 is z
    typedef logic [2:0][31:0] vec_t;

    typedef struct packed {
        logic [2:0][66:0] cr;
        vec_t             a;
    } cross_t;

    typedef struct packed {
        vec_t       a;
        logic [2:0] neg;
        logic       deg;
        logic       kill;
    } side_t;

    typedef struct packed {
        logic [2:0][30:0] u;
        logic [63:0]      s;
        side_t            side;
    } norm_t;

    typedef struct packed {
        logic [2:0][30:0] u;
        side_t            side;
    } upay_t;

    typedef struct packed {
        logic [31:0] r;
        upay_t       pay;
    } root_t;

    typedef struct packed {
        logic [2:0][30:0] q;
        side_t            side;
    } quot_t;

    function automatic logic signed [31:0] coord_ext(input logic [31:0] raw);
        logic signed [COORD_WIDTH-1:0] t;
        t = raw[COORD_WIDTH-1:0];
        return 32'(t);
    endfunction

endpackage

`default_nettype wire

>>> rtl/tpe_cross.sv
// ----------------------------------------------------------------------------
// tpe_cross
// Edge vectors and exact cross product, split into 17 bit partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module tpe_cross (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  tpe_pkg::vec_t   va,
    input  tpe_pkg::vec_t   vb,
    input  tpe_pkg::vec_t   vc,
    output logic            out_valid,
    output tpe_pkg::cross_t out
);

    logic [3:0] vld_reg;

    logic signed [31:0] ae [3];
    logic signed [31:0] be [3];
    logic signed [31:0] ce [3];

    logic signed [32:0] v_reg [3];
    logic signed [32:0] w_reg [3];
    tpe_pkg::vec_t      a1_reg;
    tpe_pkg::vec_t      a2_reg;
    tpe_pkg::vec_t      a3_reg;
    tpe_pkg::vec_t      a4_reg;

    logic signed [32:0] opa [6];
    logic signed [32:0] opb [6];

    logic signed [33:0] hh_reg [6];
    logic signed [33:0] hl_reg [6];
    logic signed [33:0] lh_reg [6];
    logic [31:0]        ll_reg [6];
    logic signed [65:0] p_reg  [6];
    logic [2:0][66:0]   cr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ae[i] = tpe_pkg::coord_ext(va[i]);
            be[i] = tpe_pkg::coord_ext(vb[i]);
            ce[i] = tpe_pkg::coord_ext(vc[i]);
        end
    end

    // operand pairs of the six products: x = p0-p1, y = p2-p3, z = p4-p5
    always_comb
    begin
        opa[0] = v_reg[1]; opb[0] = w_reg[2];
        opa[1] = v_reg[2]; opb[1] = w_reg[1];
        opa[2] = v_reg[2]; opb[2] = w_reg[0];
        opa[3] = v_reg[0]; opb[3] = w_reg[2];
        opa[4] = v_reg[0]; opb[4] = w_reg[1];
        opa[5] = v_reg[1]; opb[5] = w_reg[0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                v_reg[i]  <= 33'(be[i]) - 33'(ce[i]);
                w_reg[i]  <= 33'(ae[i]) - 33'(be[i]);
                a1_reg[i] <= ae[i];
            end
            for (int i = 0; i < 6; i++)
            begin
                hh_reg[i] <= $signed(opa[i][32:16]) * $signed(opb[i][32:16]);
                hl_reg[i] <= $signed(opa[i][32:16]) * $signed({1'b0, opb[i][15:0]});
                lh_reg[i] <= $signed({1'b0, opa[i][15:0]}) * $signed(opb[i][32:16]);
                ll_reg[i] <= opa[i][15:0] * opb[i][15:0];
                p_reg[i]  <= (66'(hh_reg[i]) <<< 32) + (66'(hl_reg[i]) <<< 16)
                           + (66'(lh_reg[i]) <<< 16) + 66'(ll_reg[i]);
            end
            for (int i = 0; i < 3; i++)
            begin
                cr_reg[i] <= 67'(p_reg[2*i]) - 67'(p_reg[2*i+1]);
            end
            a2_reg <= a1_reg;
            a3_reg <= a2_reg;
            a4_reg <= a3_reg;
        end
    end

    assign out_valid = vld_reg[3];
    assign out.cr    = cr_reg;
    assign out.a     = a4_reg;

endmodule

`default_nettype wire

>>> rtl/tpe_norm.sv
// ----------------------------------------------------------------------------
// tpe_norm
// Magnitudes, leading bit search, degenerate test and 31 bit scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module tpe_norm (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  tpe_pkg::cross_t in,
    input  logic [31:0]     limit,
    output logic            out_valid,
    output tpe_pkg::norm_t  out
);

    logic [5:0] vld_reg;

    logic [65:0]   mag5_reg [3];
    logic [2:0]    neg5_reg;
    tpe_pkg::vec_t a5_reg;

    logic [71:0] orp;
    logic [8:0]  cnz;
    logic [3:0]  clen [9];

    logic [65:0]   mag6_reg [3];
    logic [2:0]    neg6_reg;
    tpe_pkg::vec_t a6_reg;
    logic [8:0]    nz6_reg;
    logic [3:0]    len6_reg [9];
    logic          small6_reg;
    logic [63:0]   sq6_reg [3];
    logic [63:0]   limsq6_reg;

    logic [6:0]  m_c;
    logic [65:0] sqsum;

    logic [65:0]   mag7_reg [3];
    logic [2:0]    neg7_reg;
    tpe_pkg::vec_t a7_reg;
    logic [6:0]    m7_reg;
    logic          deg7_reg;

    logic [2:0][30:0] u_c;
    logic [2:0][30:0] u8_reg;
    tpe_pkg::side_t   side8_reg;

    logic [61:0]      usq9_reg [3];
    logic [2:0][30:0] u9_reg;
    tpe_pkg::side_t   side9_reg;

    logic [63:0]      s10_reg;
    logic [2:0][30:0] u10_reg;
    tpe_pkg::side_t   side10_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    // the longest magnitude sets the bit length of the or of all three
    always_comb
    begin
        orp = {6'd0, mag5_reg[0] | mag5_reg[1] | mag5_reg[2]};
        for (int k = 0; k < 9; k++)
        begin
            cnz[k]  = |orp[k*8 +: 8];
            clen[k] = 4'd0;
            for (int j = 0; j < 8; j++)
            begin
                if (orp[k*8 + j])
                begin
                    clen[k] = 4'(j + 1);
                end
            end
        end
    end

    always_comb
    begin
        m_c = 7'd0;
        for (int k = 0; k < 9; k++)
        begin
            if (nz6_reg[k])
            begin
                m_c = 7'(k * 8) + 7'(len6_reg[k]);
            end
        end
        sqsum = 66'(sq6_reg[0]) + 66'(sq6_reg[1]) + 66'(sq6_reg[2]);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (m7_reg > 7'd31)
            begin
                u_c[i] = 31'(mag7_reg[i] >> (m7_reg - 7'd31));
            end
            else
            begin
                u_c[i] = mag7_reg[i][30:0] << (7'd31 - m7_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg5_reg[i] <= in.cr[i][66];
                mag5_reg[i] <= in.cr[i][66] ? 66'(-in.cr[i]) : in.cr[i][65:0];
                sq6_reg[i]  <= mag5_reg[i][31:0] * mag5_reg[i][31:0];
                usq9_reg[i] <= u8_reg[i] * u8_reg[i];
            end
            a5_reg <= in.a;

            mag6_reg   <= mag5_reg;
            neg6_reg   <= neg5_reg;
            a6_reg     <= a5_reg;
            nz6_reg    <= cnz;
            len6_reg   <= clen;
            small6_reg <= (orp[65:32] == '0);
            limsq6_reg <= 64'(limit) * 64'(limit);

            mag7_reg <= mag6_reg;
            neg7_reg <= neg6_reg;
            a7_reg   <= a6_reg;
            m7_reg   <= m_c;
            deg7_reg <= small6_reg && (sqsum < 66'(limsq6_reg));

            u8_reg         <= u_c;
            side8_reg.a    <= a7_reg;
            side8_reg.neg  <= neg7_reg;
            side8_reg.deg  <= deg7_reg;
            side8_reg.kill <= deg7_reg || (m7_reg == 7'd0);

            u9_reg    <= u8_reg;
            side9_reg <= side8_reg;

            s10_reg    <= 64'(usq9_reg[0]) + 64'(usq9_reg[1]) + 64'(usq9_reg[2]);
            u10_reg    <= u9_reg;
            side10_reg <= side9_reg;
        end
    end

    assign out_valid = vld_reg[5];
    assign out.u     = u10_reg;
    assign out.s     = s10_reg;
    assign out.side  = side10_reg;

endmodule

`default_nettype wire

>>> rtl/tpe_sqrt.sv
// ----------------------------------------------------------------------------
// tpe_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tpe_sqrt (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  tpe_pkg::norm_t in,
    output logic           out_valid,
    output tpe_pkg::root_t out
);

    localparam int N = tpe_pkg::SQRT_STEPS;

    logic           vld_reg  [N];
    logic [63:0]    rad_reg  [N];
    logic [33:0]    rem_reg  [N];
    logic [31:0]    root_reg [N];
    tpe_pkg::upay_t pay_reg  [N];

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic           vld_i;
        logic [63:0]    rad_i;
        logic [33:0]    rem_i;
        logic [31:0]    root_i;
        tpe_pkg::upay_t pay_i;
        logic [35:0]    trial;
        logic [35:0]    test;
        logic           ge;

        if (k == 0)
        begin : g_first
            assign vld_i      = in_valid;
            assign rad_i      = in.s;
            assign rem_i      = '0;
            assign root_i     = '0;
            assign pay_i.u    = in.u;
            assign pay_i.side = in.side;
        end
        else
        begin : g_next
            assign vld_i  = vld_reg[k-1];
            assign rad_i  = rad_reg[k-1];
            assign rem_i  = rem_reg[k-1];
            assign root_i = root_reg[k-1];
            assign pay_i  = pay_reg[k-1];
        end

        assign trial = {rem_i, rad_i[63:62]};
        assign test  = {2'b00, root_i, 2'b01};
        assign ge    = (trial >= test);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_i;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= rad_i << 2;
                rem_reg[k]  <= ge ? 34'(trial - test) : trial[33:0];
                root_reg[k] <= {root_i[30:0], ge};
                pay_reg[k]  <= pay_i;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out.r     = root_reg[N-1];
    assign out.pay   = pay_reg[N-1];

endmodule

`default_nettype wire

>>> rtl/tpe_div.sv
// ----------------------------------------------------------------------------
// tpe_div
// Three lane pipelined restoring divider: q = (u * 2^31 + r) / (2 r).
// ----------------------------------------------------------------------------
`default_nettype none

module tpe_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  tpe_pkg::root_t in,
    output logic           out_valid,
    output tpe_pkg::quot_t out
);

    localparam int N = tpe_pkg::DIV_STEPS;

    logic             vld_reg  [N];
    logic [31:0]      r_reg    [N];
    logic [2:0][32:0] rem_reg  [N];
    logic [2:0][30:0] q_reg    [N];
    tpe_pkg::side_t   side_reg [N];

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic             vld_i;
        logic [31:0]      r_i;
        logic [2:0][32:0] rem_i;
        logic [2:0][30:0] q_i;
        tpe_pkg::side_t   side_i;
        logic [33:0]      dvs;
        logic [2:0][33:0] t;
        logic [2:0]       ge;

        if (k == 0)
        begin : g_first
            // top bits of the dividend are u plus the carry-in of r bit 31
            assign vld_i  = in_valid;
            assign r_i    = in.r;
            assign q_i    = '0;
            assign side_i = in.pay.side;
            for (genvar l = 0; l < 3; l++)
            begin : g_lane
                assign rem_i[l] = 33'(in.pay.u[l]) + 33'(in.r[31]);
            end
        end
        else
        begin : g_next
            assign vld_i  = vld_reg[k-1];
            assign r_i    = r_reg[k-1];
            assign rem_i  = rem_reg[k-1];
            assign q_i    = q_reg[k-1];
            assign side_i = side_reg[k-1];
        end

        assign dvs = {1'b0, r_i, 1'b0};

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                t[l]  = {rem_i[l], r_i[N-1-k]};
                ge[l] = (t[l] >= dvs);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_i;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[k][l] <= ge[l] ? 33'(t[l] - dvs) : t[l][32:0];
                    q_reg[k][l]   <= {q_i[l][29:0], ge[l]};
                end
                r_reg[k]    <= r_i;
                side_reg[k] <= side_i;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out.q     = q_reg[N-1];
    assign out.side  = side_reg[N-1];

endmodule

`default_nettype wire

>>> rtl/triangle_plane_equation.sv
// ----------------------------------------------------------------------------
// triangle_plane_equation
// Unit normal and plane offset of a triangle given by three Q16.16 vertices.
// ----------------------------------------------------------------------------
// Input beats on s_*: nine 32 bit coordinates A, B, C. Output beats on m_*:
// the unit normal in Q1.30, the plane offset d = -(n . A) with 16 fraction
// bits, and the degenerate flag in m_tuser. The cfg channel writes the
// degenerate limit (cross product length in 2^-32 units); cfg_ready is
// always high and writes belong to idle periods.
// An accepted beat passes 4 cross product stages, 6 scaling stages, 32
// square root stages (one root bit each), 31 divider stages (one quotient
// bit each) and 4 stages of dot product, rounding and output register.
// One beat is taken every cycle while the receiver does not stall.
// A receiver stall holds the whole pipeline in place: s_tready follows
// m_tready while a result is waiting, so nothing is dropped or repeated.
// Reset clears every valid bit and loads the limit with 4295.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_plane_equation (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_x, first_y, first_z, second_x .. second_z, third_x .. third_z
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // normal_x, normal_y, normal_z, plane_offset, zero padding
    output logic [135:0] m_tdata,
    // degenerate
    output logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);

    localparam logic signed [37:0] OFF_MAX = 38'sd8589934591;
    localparam logic signed [37:0] OFF_MIN = -38'sd8589934592;

    logic en;
    logic [31:0] limit_reg;

    logic            cr_valid;
    tpe_pkg::cross_t cr;
    logic            nm_valid;
    tpe_pkg::norm_t  nm;
    logic            rt_valid;
    tpe_pkg::root_t  rt;
    logic            qt_valid;
    tpe_pkg::quot_t  qt;

    logic [2:0] vld_reg;

    logic [2:0][31:0]   na_reg;
    tpe_pkg::vec_t      aa_reg;
    logic               dega_reg;
    logic signed [63:0] pb_reg [3];
    logic [2:0][31:0]   nb_reg;
    logic               degb_reg;
    logic signed [65:0] dot_reg;
    logic [2:0][31:0]   nc_reg;
    logic               degc_reg;

    logic [2:0][31:0]   n_c;
    logic [65:0]        dmag;
    logic [36:0]        qr;
    logic signed [37:0] off_c;
    logic [33:0]        off_sat;

    logic               out_vld_reg;
    logic [2:0][31:0]   nout_reg;
    logic [33:0]        off_reg;
    logic               deg_reg;

    assign en        = !out_vld_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= tpe_pkg::DEG_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    tpe_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .va        (s_tdata[95:0]),
        .vb        (s_tdata[191:96]),
        .vc        (s_tdata[287:192]),
        .out_valid (cr_valid),
        .out       (cr)
    );

    tpe_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cr_valid),
        .in        (cr),
        .limit     (limit_reg),
        .out_valid (nm_valid),
        .out       (nm)
    );

    tpe_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nm_valid),
        .in        (nm),
        .out_valid (rt_valid),
        .out       (rt)
    );

    tpe_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rt_valid),
        .in        (rt),
        .out_valid (qt_valid),
        .out       (qt)
    );

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (qt.side.kill)
            begin
                n_c[l] = '0;
            end
            else if (qt.side.neg[l])
            begin
                n_c[l] = 32'd0 - 32'(qt.q[l]);
            end
            else
            begin
                n_c[l] = 32'(qt.q[l]);
            end
        end
    end

    // round half away from zero, then clamp to 34 bits
    always_comb
    begin
        dmag  = dot_reg[65] ? 66'(-dot_reg) : 66'(dot_reg);
        qr    = 37'((dmag + 66'(64'd1 << 29)) >> 30);
        off_c = dot_reg[65] ? $signed({1'b0, qr}) : -$signed({1'b0, qr});
        if (off_c > OFF_MAX)
        begin
            off_sat = OFF_MAX[33:0];
        end
        else if (off_c < OFF_MIN)
        begin
            off_sat = OFF_MIN[33:0];
        end
        else
        begin
            off_sat = off_c[33:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[1:0], qt_valid};
            out_vld_reg <= vld_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            na_reg   <= n_c;
            aa_reg   <= qt.side.a;
            dega_reg <= qt.side.deg;

            for (int l = 0; l < 3; l++)
            begin
                pb_reg[l] <= $signed(na_reg[l]) * $signed(aa_reg[l]);
            end
            nb_reg   <= na_reg;
            degb_reg <= dega_reg;

            dot_reg  <= 66'(pb_reg[0]) + 66'(pb_reg[1]) + 66'(pb_reg[2]);
            nc_reg   <= nb_reg;
            degc_reg <= degb_reg;

            nout_reg <= nc_reg;
            off_reg  <= off_sat;
            deg_reg  <= degc_reg;
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = {6'd0, off_reg, nout_reg};
    assign m_tuser[0] = deg_reg;

    // a degenerate triangle carries no normal and no offset
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[129:0] == '0)
        else $error("degenerate result with nonzero payload");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(m_tdata[31:0]) <= 32'sd1073741824
            && $signed(m_tdata[31:0]) >= -32'sd1073741824
            && $signed(m_tdata[63:32]) <= 32'sd1073741824
            && $signed(m_tdata[63:32]) >= -32'sd1073741824
            && $signed(m_tdata[95:64]) <= 32'sd1073741824
            && $signed(m_tdata[95:64]) >= -32'sd1073741824)
        else $error("normal component outside unit range");

    a_zero_normal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[95:0] == '0 |-> m_tdata[129:96] == '0)
        else $error("offset without a normal");

endmodule

`default_nettype wire

>>> tb/sv/triangle_plane_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_plane_checker
// Watches the input, output and limit channels of triangle_plane_equation.
// It predicts each plane from the accepted vertex beats and compares it,
// field by field, with the result beats in order.
// ----------------------------------------------------------------------------

module triangle_plane_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [287:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,
    input  logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [31:0]  cfg_data,
    output int           failures,
    output int           outstanding,
    output int           planes_seen,
    output int           flat_seen
);

    typedef struct packed {
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] nz;
        logic [33:0] offset;
        logic        degenerate;
    } plane_t;

    plane_t      pending_planes[$];
    logic [31:0] limit_reg;

    function automatic logic signed [127:0] vertex_coord(input logic [31:0] raw);
        logic [63:0] t;
        t = {32'b0, raw} << (64 - tpe_pkg::COORD_WIDTH);
        return 128'($signed(t) >>> (64 - tpe_pkg::COORD_WIDTH));
    endfunction

    function automatic logic [63:0] floor_root(input logic [63:0] val);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > val)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (val >= res + bitv)
            begin
                val = val - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic plane_t predict_plane(input logic [287:0] verts, input logic [31:0] lim);
        logic signed [127:0] a[3], b[3], c[3], v[3], w[3], cr[3], n[3];
        logic signed [127:0] dot, off, q2;
        logic [127:0]        mg[3], um;
        logic                neg[3];
        logic [65:0]         sq_sum;
        logic [63:0]         u[3], s, r, q;
        logic                deg;
        int                  m;
        plane_t              p;
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = vertex_coord(verts[32*i +: 32]);
            b[i] = vertex_coord(verts[32*(3+i) +: 32]);
            c[i] = vertex_coord(verts[32*(6+i) +: 32]);
            v[i] = b[i] - c[i];
            w[i] = a[i] - b[i];
            n[i] = 0;
        end
        cr[0] = v[1] * w[2] - v[2] * w[1];
        cr[1] = v[2] * w[0] - v[0] * w[2];
        cr[2] = v[0] * w[1] - v[1] * w[0];
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = cr[i] < 0;
            mg[i]  = neg[i] ? -cr[i] : cr[i];
            for (int k = 127; k >= 0; k--)
                if (mg[i][k] && k + 1 > m)
                begin
                    m = k + 1;
                    break;
                end
        end
        if (m <= 32)
        begin
            sq_sum = 66'(mg[0][31:0]) * 66'(mg[0][31:0]) + 66'(mg[1][31:0]) * 66'(mg[1][31:0])
                   + 66'(mg[2][31:0]) * 66'(mg[2][31:0]);
            deg = sq_sum < 66'(lim) * 66'(lim);
        end
        else
            deg = 1'b0;
        off = 0;
        if (!deg && m > 0)
        begin
            s = 0;
            for (int i = 0; i < 3; i++)
            begin
                u[i] = (m > 31) ? 64'(mg[i] >> (m - 31)) : 64'(mg[i] << (31 - m));
                s = s + u[i] * u[i];
            end
            r = floor_root(s);
            for (int i = 0; i < 3; i++)
            begin
                q    = ((u[i] << 31) + r) / (2 * r);
                n[i] = neg[i] ? -128'(q) : 128'(q);
            end
            dot = n[0] * a[0] + n[1] * a[1] + n[2] * a[2];
            um  = dot < 0 ? -dot : dot;
            q2  = 128'((um + (128'd1 << 29)) >> 30);
            off = dot < 0 ? q2 : -q2;
            // clamp to the 34 bit offset field
            if (off > (128'sd1 <<< 33) - 1)
                off = (128'sd1 <<< 33) - 1;
            if (off < -(128'sd1 <<< 33))
                off = -(128'sd1 <<< 33);
        end
        p.nx         = n[0][31:0];
        p.ny         = n[1][31:0];
        p.nz         = n[2][31:0];
        p.offset     = off[33:0];
        p.degenerate = deg;
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        plane_t want, got;
        if (!rst_n)
        begin
            limit_reg = tpe_pkg::DEG_LIMIT_RESET;
            pending_planes.delete();
            failures    = 0;
            outstanding = 0;
            planes_seen = 0;
            flat_seen   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                pending_planes.insert(pending_planes.size(), predict_plane(s_tdata, limit_reg));
            if (m_tvalid && m_tready)
            begin
                got.nx         = m_tdata[31:0];
                got.ny         = m_tdata[63:32];
                got.nz         = m_tdata[95:64];
                got.offset     = m_tdata[129:96];
                got.degenerate = m_tuser[0];
                planes_seen++;
                if (got.degenerate)
                    flat_seen++;
                if (pending_planes.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("result beat with nothing expected: %h %b", m_tdata, m_tuser);
                end
                else
                begin
                    want = pending_planes.pop_front();
                    if (want != got)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("plane mismatch exp n=(%h %h %h) d=%h deg=%b got n=(%h %h %h) d=%h deg=%b",
                                     want.nx, want.ny, want.nz, want.offset, want.degenerate,
                                     got.nx, got.ny, got.nz, got.offset, got.degenerate);
                    end
                end
            end
            // limit writes only happen while idle
            if (cfg_valid && cfg_ready)
                limit_reg = cfg_data;
            outstanding = pending_planes.size();
        end
    end

endmodule

>>> tb/sv/triangle_plane_equation_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_plane_equation_tb
// Drives vertex beats and limit writes into triangle_plane_equation with
// random gaps and stalls; a checker beside the block predicts every plane.
// ----------------------------------------------------------------------------

module triangle_plane_equation_tb;

    localparam int CYCLE_LIMIT = 900000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [287:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [31:0]  cfg_data;

    int failures, outstanding, planes_seen, flat_seen;
    int tris_sent;
    int cycles;
    bit calm;
    int stall_requests, stalls_done;

    triangle_plane_equation dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    triangle_plane_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .failures(failures), .outstanding(outstanding),
        .planes_seen(planes_seen), .flat_seen(flat_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d planes outstanding", cycles, outstanding);
            $display("FAIL triangle_plane_equation");
            $finish;
        end
    end

    // receiver side: random ready bursts, long hold-offs on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (stalls_done < stall_requests)
            begin
                m_tready <= 1'b0;
                repeat (500) @(posedge clk);
                stalls_done++;
            end
            else if (calm || $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
        end
    end

    function automatic logic [287:0] tri_of(input logic [31:0] ax, ay, az, bx, by, bz,
                                            cx, cy, cz);
        return {cz, cy, cx, bz, by, bx, az, ay, ax};
    endfunction

    task automatic send_tri(input logic [287:0] verts, input bit gappy);
        if (gappy && !calm && $urandom_range(0, 2) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= verts;
        do
            @(posedge clk);
        while (!s_tready);
        tris_sent++;
    endtask

    task automatic drain_all();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] lim);
        drain_all();
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] odd_value();
        case ($urandom_range(0, 5))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return 32'h0;
            3:       return 32'hffffffff;
            4:       return 32'h1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [287:0] random_tri();
        logic [31:0] p[9];
        logic [31:0] base[3];
        int          k;
        for (int i = 0; i < 3; i++)
            base[i] = $urandom;
        k = $urandom_range(0, 16);
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                for (int i = 0; i < 9; i++)
                    p[i] = $urandom;
            4, 5:
                // small triangle around a random point
                for (int i = 0; i < 9; i++)
                    p[i] = base[i % 3] + $urandom_range(0, 1 << k) - (1 << (k - 1 < 0 ? 0 : k - 1));
            6:
            begin
                // collinear or coincident vertices
                for (int i = 0; i < 3; i++)
                begin
                    p[i]     = $urandom;
                    p[3 + i] = $urandom_range(0, 1) ? p[i] : $urandom;
                    p[6 + i] = p[3 + i] + (p[3 + i] - p[i]);
                end
            end
            7:
            begin
                for (int i = 0; i < 9; i++)
                    p[i] = $urandom;
                k = $urandom_range(0, 2);
                p[3 + k] = p[k];
                p[6 + k] = p[k];
            end
            8:
                for (int i = 0; i < 9; i++)
                    p[i] = odd_value();
            default:
                // cross product near the limit
                for (int i = 0; i < 9; i++)
                    p[i] = base[i % 3] + $urandom_range(0, 100);
        endcase
        return tri_of(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8]);
    endfunction

    task automatic random_batch(input int count);
        for (int i = 0; i < count; i++)
            send_tri(random_tri(), 1'b1);
    endtask

    task automatic directed_set();
        send_tri(tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        send_tri(tri_of(5, 6, 7, 5, 6, 7, 5, 6, 7), 1'b0);
        send_tri(tri_of(0, 65536, 0, 0, 0, 0, 65536, 0, 0), 1'b0);
        send_tri(tri_of(65536, 0, 0, 0, 65536, 0, 0, 0, 65536), 1'b1);
        send_tri(tri_of(0, 0, 65536, 0, 65536, 0, 65536, 0, 0), 1'b1);
        // at and just below the reset limit
        send_tri(tri_of(4295, 1, 0, 4295, 0, 0, 0, 0, 0), 1'b1);
        send_tri(tri_of(4294, 1, 0, 4294, 0, 0, 0, 0, 0), 1'b1);
        send_tri(tri_of(1, 1, 0, 1, 0, 0, 0, 0, 0), 1'b1);
        send_tri(tri_of(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                        32'h80000000, 32'h80000000, 0, 0, 0), 1'b1);
        send_tri(tri_of(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                        32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                        32'h80000000), 1'b1);
        send_tri(tri_of(32'h80000000, 0, 0, 0, 32'h7fffffff, 0, 0, 0, 32'h80000000), 1'b1);
        send_tri(tri_of(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, 0,
                        0, 32'h80000000, 0), 1'b1);
        send_tri(tri_of(32'hffffffff, 32'hffffffff, 32'hffffffff, 1, 1, 1, 3, 3, 3), 1'b1);
        send_tri(tri_of(32'hfffe0000, 32'h00030000, 32'h7f000000, 32'h00010000,
                        32'hffff0000, 32'h80100000, 32'h12345678, 32'h9abcdef0,
                        32'h0f0f0f0f), 1'b1);
        send_tri(tri_of(32'h00100000, 32'h00100000, 32'h00100000, 0, 0, 0,
                        32'h00100001, 32'h00100000, 32'h00100000), 1'b1);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        cycles    = 0;
        tris_sent = 0;
        calm      = 1'b0;
        stall_requests = 0;
        stalls_done    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_set();
        random_batch(150);

        // zero limit: a zero cross product is no longer flagged
        write_limit(32'h0);
        directed_set();
        random_batch(150);

        // fill the pipeline against a held-off receiver
        write_limit(32'hffffffff);
        stall_requests = 1;
        random_batch(200);

        write_limit($urandom);
        random_batch(100);
        // sender waits for every plane before going on
        drain_all();
        random_batch(100);

        write_limit($urandom_range(0, 100000));
        random_batch(200);

        write_limit(tpe_pkg::DEG_LIMIT_RESET);
        random_batch(150);
        calm = 1'b1;
        random_batch(220);

        drain_all();
        $display("%0d triangles over six limit settings, %0d planes checked, %0d flagged degenerate",
                 tris_sent, planes_seen, flat_seen);
        if (failures == 0)
            $display("PASS triangle_plane_equation");
        else
            $display("FAIL triangle_plane_equation");
        $finish;
    end

endmodule
